[hw/rtl/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// WAV stream parser package
// Shared constants, parse phases and the control interface between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
    localparam logic [15:0] FMT_TAG_PCM    = 16'h0001;
    localparam logic [15:0] FMT_TAG_FLOAT  = 16'h0003;
    localparam logic [15:0] FMT_TAG_EXT    = 16'hFFFE;

    localparam int SUM_W = 30;
    localparam int SMP_W = 24;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_SHORT    = 4'd1;
    localparam logic [3:0] ERR_NOT_RIFF = 4'd2;
    localparam logic [3:0] ERR_NO_FMT   = 4'd3;
    localparam logic [3:0] ERR_NO_DATA  = 4'd4;
    localparam logic [3:0] ERR_BAD_FMT  = 4'd5;
    localparam logic [3:0] ERR_TAG      = 4'd6;
    localparam logic [3:0] ERR_WIDTH    = 4'd7;
    localparam logic [3:0] ERR_CHANNELS = 4'd8;

    typedef enum logic [5:0] {
        PH_RIFF = 6'b000001,
        PH_HDR  = 6'b000010,
        PH_FMT  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_SKIP = 6'b010000,
        PH_SINK = 6'b100000
    } t_phase;

    typedef struct packed {
        logic take;
        logic load;
        logic step;
        logic div_start;
        logic out_sample;
        logic out_end;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic last;
        logic div_done;
        logic out_taken;
    } t_status;

endpackage

[hw/rtl/wsp_div.sv]
// ----------------------------------------------------------------------------
// WAV stream parser frame divider
// Signed frame sum divided by the channel count, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module wsp_div
    import wsp_pkg::*;
#(
    parameter int DIV_W = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [SMP_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIV_W:0]     r_rem, n_rem;
    logic [SUM_W-1:0]   r_q, n_q;
    logic [DIV_W-1:0]   r_dsr, n_dsr;
    logic               r_neg, n_neg;
    logic [DIV_W:0]     trial;
    logic [SMP_W-1:0]   mag;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dsr  = r_dsr;
        n_neg  = r_neg;
        trial  = {r_rem[DIV_W-1:0], r_q[SUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_neg  = i_dividend[SUM_W-1];
            n_q    = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = trial - {1'b0, r_dsr};
                n_q   = {r_q[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_q   = {r_q[SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dsr <= n_dsr;
        r_neg <= n_neg;
    end

    assign mag        = r_q[SMP_W-1:0];
    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(mag) : $signed(mag);

endmodule

[hw/rtl/wsp_datapath.sv]
// ----------------------------------------------------------------------------
// WAV stream parser datapath
// Chunk walker, format decoder, sample converter, frame accumulator and the
// result register.
// ----------------------------------------------------------------------------
module wsp_datapath
    import wsp_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [1:0]              o_kind,
    output logic signed [SMP_W-1:0] o_sample,
    output logic [3:0]              o_err,
    output logic [31:0]             o_rate,
    output logic [15:0]             o_channels
);

    localparam int CI_W = $clog2(MAX_CHANNELS + 1);
    localparam logic [15:0] MAX_CH = 16'(MAX_CHANNELS);

    logic [7:0]  r_byte;
    logic        r_last;
    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_remain, n_remain;
    logic        r_pad, n_pad;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_hdr_size, n_hdr_size;
    logic [15:0] r_f_tag, n_f_tag;
    logic [15:0] r_f_ch, n_f_ch;
    logic [31:0] r_f_rate, n_f_rate;
    logic [15:0] r_f_bits, n_f_bits;
    logic [15:0] r_p_tag, n_p_tag;
    logic [15:0] r_p_ch, n_p_ch;
    logic [31:0] r_p_rate, n_p_rate;
    logic [15:0] r_p_bits, n_p_bits;
    logic [15:0] r_p_valid, n_p_valid;
    logic [15:0] r_p_sub, n_p_sub;
    logic [4:0]  r_fmt_off, n_fmt_off;
    logic        r_fmt_ext, n_fmt_ext;
    logic        r_have, n_have;
    logic        r_data_seen, n_data_seen;
    logic        r_stream_ok, n_stream_ok;
    logic [31:0] r_dcount, n_dcount;
    logic [31:0] r_sample, n_sample;
    logic [1:0]  r_bis, n_bis;
    logic [CI_W-1:0] r_idx, n_idx;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic        r_tag_err, n_tag_err;

    logic                    r_o_valid;
    logic [1:0]              r_o_kind;
    logic signed [SMP_W-1:0] r_o_sample;
    logic [3:0]              r_o_err;
    logic [31:0]             r_o_rate;
    logic [15:0]             r_o_ch;

    logic                    frame_done;
    logic signed [SUM_W-1:0] sum_new;
    logic [31:0]             hsize;
    logic [31:0]             sb;
    logic [2:0]              bis1;
    logic [CI_W-1:0]         idx1;
    logic signed [SMP_W-1:0] conv;
    logic [28:0]             frame_bytes;
    logic                    frame_ok;
    logic [3:0]              end_err;
    logic                    div_done;
    logic signed [SMP_W-1:0] quotient;

    function automatic logic signed [SMP_W-1:0] float_q23(input logic [31:0] u);
        logic [7:0]  e;
        logic [22:0] m;
        logic [7:0]  sh;
        logic [23:0] mag;
        logic signed [SMP_W-1:0] sat;
        e   = u[30:23];
        m   = u[22:0];
        sh  = 8'd127 - e;
        sat = u[31] ? -24'sd8388608 : 24'sd8388607;
        mag = (sh < 8'd32) ? ({1'b1, m} >> sh[4:0]) : 24'd0;
        if (e == 8'd255) begin
            float_q23 = (m != 23'd0) ? '0 : sat;
        end else if (e == 8'd0) begin
            float_q23 = '0;
        end else if (e >= 8'd127) begin
            float_q23 = sat;
        end else begin
            float_q23 = u[31] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    function automatic logic [3:0] fmt_error(input logic frame_exists, input logic [15:0] tag,
                                             input logic [15:0] ch, input logic [31:0] rate,
                                             input logic [15:0] bits);
        logic combo;
        combo = (tag == FMT_TAG_PCM && (bits == 16'd8 || bits == 16'd16 || bits == 16'd32))
             || (tag == FMT_TAG_FLOAT && bits == 16'd32);
        priority if (ch == 16'd0 || rate == 32'd0) fmt_error = ERR_BAD_FMT;
        else if (tag != FMT_TAG_PCM && tag != FMT_TAG_FLOAT) fmt_error = ERR_TAG;
        else if (bits < 16'd8) fmt_error = ERR_WIDTH;
        else if (ch > MAX_CH) fmt_error = ERR_CHANNELS;
        else if (!combo && frame_exists) fmt_error = ERR_WIDTH;
        else fmt_error = ERR_NONE;
    endfunction

    always_comb begin
        n_phase = r_phase;  n_pos = r_pos;  n_tag = r_tag;  n_remain = r_remain;
        n_pad = r_pad;  n_hdr_cnt = r_hdr_cnt;  n_hdr_size = r_hdr_size;
        n_f_tag = r_f_tag;  n_f_ch = r_f_ch;  n_f_rate = r_f_rate;  n_f_bits = r_f_bits;
        n_p_tag = r_p_tag;  n_p_ch = r_p_ch;  n_p_rate = r_p_rate;  n_p_bits = r_p_bits;
        n_p_valid = r_p_valid;  n_p_sub = r_p_sub;  n_fmt_off = r_fmt_off;
        n_fmt_ext = r_fmt_ext;  n_have = r_have;  n_data_seen = r_data_seen;
        n_stream_ok = r_stream_ok;  n_dcount = r_dcount;  n_sample = r_sample;
        n_bis = r_bis;  n_idx = r_idx;  n_sum = r_sum;  n_tag_err = r_tag_err;
        frame_done = 1'b0;
        sum_new = r_sum;
        hsize = r_hdr_size;
        sb = r_sample | (32'(r_byte) << {r_bis, 3'b000});
        bis1 = {1'b0, r_bis} + 3'd1;
        idx1 = r_idx + 1'b1;
        conv = '0;
        if (i_cmd.step) begin
            unique case (r_phase)
                PH_RIFF: begin
                    n_tag = {r_tag[23:0], r_byte};
                    if (r_pos == 32'd3 && n_tag != TAG_RIFF) begin
                        n_tag_err = 1'b1;
                        n_phase = PH_SINK;
                    end else if (r_pos == 32'd11) begin
                        if (n_tag != TAG_WAVE) begin
                            n_tag_err = 1'b1;
                            n_phase = PH_SINK;
                        end else begin
                            n_phase = PH_HDR;
                            n_hdr_cnt = '0;
                        end
                    end
                end
                PH_HDR: begin
                    if (!r_hdr_cnt[2]) begin
                        n_tag = {r_tag[23:0], r_byte};
                        hsize = '0;
                    end else begin
                        hsize = r_hdr_size | (32'(r_byte) << {r_hdr_cnt[1:0], 3'b000});
                    end
                    n_hdr_size = hsize;
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                    if (r_hdr_cnt == 3'd7) begin
                        n_remain = hsize;
                        n_pad = hsize[0];
                        if (n_tag == TAG_FMT && hsize >= 32'd16 && !r_data_seen) begin
                            n_phase = PH_FMT;
                            n_fmt_off = '0;
                            n_fmt_ext = hsize >= 32'd26;
                            n_p_tag = '0;  n_p_ch = '0;  n_p_rate = '0;
                            n_p_bits = '0;  n_p_valid = '0;  n_p_sub = '0;
                        end else if (n_tag == TAG_DATA && !r_data_seen) begin
                            n_data_seen = 1'b1;
                            n_stream_ok = r_have && fmt_error(1'b1, r_f_tag, r_f_ch,
                                                              r_f_rate, r_f_bits) == ERR_NONE;
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                        if (hsize == 32'd0) n_phase = PH_HDR;
                    end
                end
                PH_FMT, PH_DATA, PH_SKIP: begin
                    if (r_phase == PH_FMT) begin
                        if (r_fmt_off < 5'd26) begin
                            n_fmt_off = r_fmt_off + 5'd1;
                            unique case (r_fmt_off)
                                5'd0:  n_p_tag[7:0]    = r_byte;
                                5'd1:  n_p_tag[15:8]   = r_byte;
                                5'd2:  n_p_ch[7:0]     = r_byte;
                                5'd3:  n_p_ch[15:8]    = r_byte;
                                5'd4:  n_p_rate[7:0]   = r_byte;
                                5'd5:  n_p_rate[15:8]  = r_byte;
                                5'd6:  n_p_rate[23:16] = r_byte;
                                5'd7:  n_p_rate[31:24] = r_byte;
                                5'd14: n_p_bits[7:0]   = r_byte;
                                5'd15: n_p_bits[15:8]  = r_byte;
                                5'd18: n_p_valid[7:0]  = r_byte;
                                5'd19: n_p_valid[15:8] = r_byte;
                                5'd24: n_p_sub[7:0]    = r_byte;
                                5'd25: n_p_sub[15:8]   = r_byte;
                                default: ;
                            endcase
                            if (r_fmt_off == 5'd15) begin
                                n_f_tag = n_p_tag;  n_f_ch = n_p_ch;
                                n_f_rate = n_p_rate;  n_f_bits = n_p_bits;
                                n_have = 1'b1;
                            end
                            if (r_fmt_off == 5'd25 && r_fmt_ext && n_p_tag == FMT_TAG_EXT) begin
                                if (n_p_sub == FMT_TAG_PCM || n_p_sub == FMT_TAG_FLOAT) begin
                                    n_f_tag = n_p_sub;
                                end
                                if (n_p_valid != 16'd0) n_f_bits = n_p_valid;
                            end
                        end
                    end else if (r_phase == PH_DATA) begin
                        if (r_dcount != 32'hFFFF_FFFF) n_dcount = r_dcount + 32'd1;
                        if (r_stream_ok) begin
                            if (16'(bis1) >= {3'b000, r_f_bits[15:3]}) begin
                                if (r_f_tag == FMT_TAG_FLOAT) conv = float_q23(sb);
                                else if (r_f_bits == 16'd8) conv = {sb[7] ^ 1'b1, sb[6:0], 16'h0};
                                else if (r_f_bits == 16'd16) conv = {sb[15:0], 8'h00};
                                else conv = sb[31:8];
                                sum_new = r_sum + SUM_W'(conv);
                                n_sample = '0;
                                n_bis = '0;
                                if (16'(idx1) >= r_f_ch) begin
                                    frame_done = 1'b1;
                                    n_sum = '0;
                                    n_idx = '0;
                                end else begin
                                    n_sum = sum_new;
                                    n_idx = idx1;
                                end
                            end else begin
                                n_sample = sb;
                                n_bis = r_bis + 2'd1;
                            end
                        end
                    end
                    n_remain = r_remain - 32'd1;
                    if (n_remain == 32'd0) begin
                        if (r_pad) begin
                            n_pad = 1'b0;
                            n_remain = 32'd1;
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_HDR;
                        end
                    end
                end
                PH_SINK: ;
                default: ;
            endcase
            if (r_pos != 32'hFFFF_FFFF) n_pos = r_pos + 32'd1;
        end
    end

    assign frame_bytes = 29'(r_f_bits[15:3] * r_f_ch);
    assign frame_ok = frame_bytes != 29'd0 && {3'b000, frame_bytes} <= r_dcount;

    always_comb begin
        priority if (r_pos < MIN_FILE_BYTES) end_err = ERR_SHORT;
        else if (r_tag_err) end_err = ERR_NOT_RIFF;
        else if (!r_have) end_err = ERR_NO_FMT;
        else if (!r_data_seen || r_dcount == 32'd0) end_err = ERR_NO_DATA;
        else end_err = fmt_error(frame_ok, r_f_tag, r_f_ch, r_f_rate, r_f_bits);
    end

    wsp_div #(
        .DIV_W(CI_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sum_new),
        .i_divisor  (r_f_ch[CI_W-1:0]),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_phase <= PH_RIFF;  r_pos <= '0;  r_tag <= '0;  r_remain <= '0;
            r_pad <= 1'b0;  r_hdr_cnt <= '0;  r_hdr_size <= '0;
            r_f_tag <= '0;  r_f_ch <= '0;  r_f_rate <= '0;  r_f_bits <= '0;
            r_p_tag <= '0;  r_p_ch <= '0;  r_p_rate <= '0;  r_p_bits <= '0;
            r_p_valid <= '0;  r_p_sub <= '0;  r_fmt_off <= '0;  r_fmt_ext <= 1'b0;
            r_have <= 1'b0;  r_data_seen <= 1'b0;  r_stream_ok <= 1'b0;
            r_dcount <= '0;  r_sample <= '0;  r_bis <= '0;  r_idx <= '0;
            r_sum <= '0;  r_tag_err <= 1'b0;  r_last <= 1'b0;
        end else begin
            r_phase <= n_phase;  r_pos <= n_pos;  r_tag <= n_tag;  r_remain <= n_remain;
            r_pad <= n_pad;  r_hdr_cnt <= n_hdr_cnt;  r_hdr_size <= n_hdr_size;
            r_f_tag <= n_f_tag;  r_f_ch <= n_f_ch;  r_f_rate <= n_f_rate;
            r_f_bits <= n_f_bits;  r_p_tag <= n_p_tag;  r_p_ch <= n_p_ch;
            r_p_rate <= n_p_rate;  r_p_bits <= n_p_bits;  r_p_valid <= n_p_valid;
            r_p_sub <= n_p_sub;  r_fmt_off <= n_fmt_off;  r_fmt_ext <= n_fmt_ext;
            r_have <= n_have;  r_data_seen <= n_data_seen;  r_stream_ok <= n_stream_ok;
            r_dcount <= n_dcount;  r_sample <= n_sample;  r_bis <= n_bis;
            r_idx <= n_idx;  r_sum <= n_sum;  r_tag_err <= n_tag_err;
            if (i_cmd.load) r_last <= i_last;
        end
        if (i_cmd.load) r_byte <= i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_sample || i_cmd.out_end) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_sample) begin
            r_o_kind   <= KIND_SAMPLE;
            r_o_sample <= quotient;
            r_o_err    <= ERR_NONE;
            r_o_rate   <= '0;
            r_o_ch     <= '0;
        end else if (i_cmd.out_end) begin
            r_o_kind   <= (end_err == ERR_NONE) ? KIND_OK : KIND_ERR;
            r_o_sample <= '0;
            r_o_err    <= end_err;
            r_o_rate   <= r_f_rate;
            r_o_ch     <= r_f_ch;
        end
    end

    assign o_status.frame_done = frame_done;
    assign o_status.last       = r_last;
    assign o_status.div_done   = div_done;
    assign o_status.out_taken  = r_o_valid && i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_sample    = r_o_sample;
    assign o_err       = r_o_err;
    assign o_rate      = r_o_rate;
    assign o_channels  = r_o_ch;

endmodule

[hw/rtl/wsp_ctrl.sv]
// ----------------------------------------------------------------------------
// WAV stream parser controller
// Sequences byte intake, the parse step, the frame division and the result
// transactions.
// ----------------------------------------------------------------------------
module wsp_ctrl
    import wsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_STEP  = 6'b000010,
        S_DIV   = 6'b000100,
        S_SWAIT = 6'b001000,
        S_END   = 6'b010000,
        S_EWAIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_status.frame_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_status.last) begin
                    n_state = S_END;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.out_sample = 1'b1;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (i_status.out_taken) n_state = i_status.last ? S_END : S_IDLE;
            end
            S_END: begin
                o_cmd.out_end = 1'b1;
                o_cmd.clear = 1'b1;
                n_state = S_EWAIT;
            end
            S_EWAIT: begin
                if (i_status.out_taken) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/wav_stream_parse_downmix.sv]
// ----------------------------------------------------------------------------
// WAV stream parser with mono downmix
// Parses a RIFF/WAVE byte stream and emits one averaged Q1.23 sample per
// frame, then an end-of-file status with source rate and channel count.
//
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte, tlast last_byte
// m_axis    out        tuser kind, tdata sample/status/rate/channels
//
// A byte that completes no frame is loaded in S_IDLE and parsed in S_STEP before
// ready returns. A frame-completing byte adds the bit-serial division by the
// channel count, plus the wait for the sample transaction. The last byte adds
// S_END, which registers the end status and clears state, and the end transaction.
// Reset is synchronous and returns the parser to the RIFF header.
// ----------------------------------------------------------------------------
module wav_stream_parse_downmix
    import wsp_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // mono_sample, status code, source_rate,
                                          // channel_count, zero fill
    output logic [1:0]  o_m_axis_tuser    // kind
);

    t_cmd                    cmd;
    t_status                 status;
    logic [1:0]              kind;
    logic signed [SMP_W-1:0] sample;
    logic [3:0]              err;
    logic [31:0]             rate;
    logic [15:0]             channels;

    wsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wsp_datapath #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_kind      (kind),
        .o_sample    (sample),
        .o_err       (err),
        .o_rate      (rate),
        .o_channels  (channels)
    );

    assign o_s_axis_tready = cmd.take;
    assign o_m_axis_tdata  = {4'b0000, channels, rate, err, sample};
    assign o_m_axis_tuser  = kind;

endmodule
